[hdl/mss_pkg.sv]
// Shared constants, payload types and helpers for the max-sum submatrix block.
package mss_pkg;

    // Matrix geometry
    localparam int MAX_DIM = 64;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = IDX_W + 1;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;

    // Data widths
    localparam int ELEM_W = 16;
    localparam int SUM_W  = 32;

    // Starting value of the running best
    localparam logic signed [SUM_W-1:0] BEST_INIT = -32'sd1000000000;

    // Configuration register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // One input item
    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     last_element;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [DIM_W-1:0]        top_row;
        logic [DIM_W-1:0]        left_col;
        logic [DIM_W-1:0]        bottom_row;
        logic [DIM_W-1:0]        right_col;
        logic signed [SUM_W-1:0] best_sum;
    } t_result;

    // Per-column control word passed from the sequencer to the datapath
    typedef struct packed {
        logic             valid;
        logic             first_bottom;
        logic             first_col;
        logic [IDX_W-1:0] top;
        logic [IDX_W-1:0] bottom;
        logic [IDX_W-1:0] col;
    } t_scan_ctl;

    // Out-of-range dimensions: zero acts as one, large values saturate
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hdl/max_sum_submatrix.sv]
// Top level of the max-sum submatrix block: configuration, element store, search.
//
// Usage: write row_count (index 0) and col_count (index 1) on the config
// port, then send the matrix one element per item in row-major order on
// start/i_item while busy is low; busy stays low while loading.
// Elements past rows*cols are dropped. The item marked
// last_element starts the search; busy then stays high until the result.
// The search handles one column of one top/bottom row pair per cycle in a
// pipelined shared adder/compare datapath. When the search is done the result
// appears on o_result with o_valid high for one cycle. Busy falls the cycle after.
// The next matrix may start loading at once; the store keeps old contents.
// The receiver cannot stall: o_valid pulses once; o_result keeps the result until the next launch.
// Reset sets both dimensions to 1, empties the load counter and returns
// the sequencer to idle; the element store itself is not cleared.
module max_sum_submatrix (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  mss_pkg::t_in_item            i_item,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_addr,
    input  logic [mss_pkg::DIM_W-1:0]    i_cfg_wdata,
    output logic                         o_valid,
    output mss_pkg::t_result             o_result
);
    import mss_pkg::*;

    logic [DIM_W-1:0]        r_row_count;
    logic [DIM_W-1:0]        r_col_count;
    logic [CNT_W-1:0]        r_load_idx;
    logic signed [ELEM_W-1:0] r_store [DEPTH];
    logic signed [ELEM_W-1:0] r_rd_elem;
    logic [DIM_W-1:0]        w_rows, w_cols;
    logic [CNT_W-1:0]        w_limit;
    logic                    w_accept;
    logic                    w_store_we;
    logic                    w_launch;
    t_scan_ctl               w_ctl;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic                    w_done;
    logic                    w_busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= DIM_W'(1);
            r_col_count <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ROW_COUNT: r_row_count <= i_cfg_wdata;
                REG_COL_COUNT: r_col_count <= i_cfg_wdata;
                default:       r_row_count <= r_row_count;
            endcase
        end
    end

    // Load limit from the current dimensions
    assign w_rows     = clamp_dim(r_row_count);
    assign w_cols     = clamp_dim(r_col_count);
    assign w_limit    = CNT_W'(w_rows) * CNT_W'(w_cols);
    assign w_accept   = start && !w_busy;
    assign w_store_we = w_accept && (r_load_idx < w_limit);
    assign w_launch   = w_accept && i_item.last_element;

    // Load counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
        end else if (w_launch) begin
            r_load_idx <= '0;
        end else if (w_store_we) begin
            r_load_idx <= r_load_idx + CNT_W'(1);
        end
    end

    // Element store: one write port for loading, one registered read for search
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_load_idx[ADDR_W-1:0]] <= i_item.element;
        end
        r_rd_elem <= r_store[w_rd_addr];
    end

    mss_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_launch (w_launch),
        .i_rows   (w_rows),
        .i_cols   (w_cols),
        .o_ctl    (w_ctl),
        .o_addr   (w_rd_addr),
        .o_done   (w_done),
        .o_busy   (w_busy)
    );

    mss_kadane u_kadane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_launch),
        .i_ctl    (w_ctl),
        .i_elem   (r_rd_elem),
        .o_result (o_result)
    );

    assign busy    = w_busy;
    assign o_valid = w_done;

endmodule

[hdl/mss_seq.sv]
// Search sequencer: walks top row, bottom row and column, one column per cycle.
module mss_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_launch,
    input  logic [mss_pkg::DIM_W-1:0]   i_rows,
    input  logic [mss_pkg::DIM_W-1:0]   i_cols,
    output mss_pkg::t_scan_ctl          o_ctl,
    output logic [mss_pkg::ADDR_W-1:0]  o_addr,
    output logic                        o_done,
    output logic                        o_busy
);
    import mss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_top, n_top;
    logic [IDX_W-1:0]   r_bottom, n_bottom;
    logic [IDX_W-1:0]   r_col, n_col;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [ADDR_W-1:0]  r_top_base, n_top_base;
    logic [IDX_W-1:0]   r_last_row, n_last_row;
    logic [IDX_W-1:0]   r_last_col, n_last_col;
    logic [DIM_W-1:0]   r_cols, n_cols;
    logic [1:0]         r_drain, n_drain;
    logic [ADDR_W-1:0]  w_next_base;

    // Base address of the next top row
    assign w_next_base = r_top_base + ADDR_W'(r_cols);

    // Next-state and counter logic
    always_comb begin
        n_state    = r_state;
        n_top      = r_top;
        n_bottom   = r_bottom;
        n_col      = r_col;
        n_addr     = r_addr;
        n_top_base = r_top_base;
        n_last_row = r_last_row;
        n_last_col = r_last_col;
        n_cols     = r_cols;
        n_drain    = r_drain;
        unique case (r_state)
            S_IDLE: begin
                if (i_launch) begin
                    n_state    = S_SCAN;
                    n_top      = '0;
                    n_bottom   = '0;
                    n_col      = '0;
                    n_addr     = '0;
                    n_top_base = '0;
                    n_last_row = IDX_W'(i_rows - DIM_W'(1));
                    n_last_col = IDX_W'(i_cols - DIM_W'(1));
                    n_cols     = i_cols;
                end
            end
            S_SCAN: begin
                if (r_col != r_last_col) begin
                    n_col  = r_col + IDX_W'(1);
                    n_addr = r_addr + ADDR_W'(1);
                end else begin
                    n_col = '0;
                    if (r_bottom != r_last_row) begin
                        n_bottom = r_bottom + IDX_W'(1);
                        n_addr   = r_addr + ADDR_W'(1);
                    end else if (r_top != r_last_row) begin
                        n_top      = r_top + IDX_W'(1);
                        n_bottom   = r_top + IDX_W'(1);
                        n_top_base = w_next_base;
                        n_addr     = w_next_base;
                    end else begin
                        n_state = S_DRAIN;
                        n_drain = '0;
                    end
                end
            end
            S_DRAIN: begin
                // wait for the datapath pipeline to empty
                if (r_drain == 2'd2) begin
                    n_state = S_DONE;
                end else begin
                    n_drain = r_drain + 2'd1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_top      <= n_top;
        r_bottom   <= n_bottom;
        r_col      <= n_col;
        r_addr     <= n_addr;
        r_top_base <= n_top_base;
        r_last_row <= n_last_row;
        r_last_col <= n_last_col;
        r_cols     <= n_cols;
        r_drain    <= n_drain;
    end

    // Control word for the column issued this cycle
    always_comb begin
        o_ctl.valid        = (r_state == S_SCAN);
        o_ctl.first_bottom = (r_bottom == r_top);
        o_ctl.first_col    = (r_col == '0);
        o_ctl.top          = r_top;
        o_ctl.bottom       = r_bottom;
        o_ctl.col          = r_col;
    end

    assign o_addr = r_addr;
    assign o_done = (r_state == S_DONE);
    assign o_busy = (r_state != S_IDLE);

endmodule

[hdl/mss_kadane.sv]
// Column-sum accumulator, Kadane scan and best-rectangle tracker.
module mss_kadane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clear,
    input  mss_pkg::t_scan_ctl                 i_ctl,
    input  logic signed [mss_pkg::ELEM_W-1:0]  i_elem,
    output mss_pkg::t_result                   o_result
);
    import mss_pkg::*;

    logic signed [SUM_W-1:0] r_csum_mem [MAX_DIM];
    logic signed [SUM_W-1:0] r_csum_q;
    t_scan_ctl               r_c1, r_s2, r_s3;
    logic signed [SUM_W-1:0] r_s2_sum;
    logic signed [SUM_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0]        r_start, n_start;
    logic signed [SUM_W-1:0] r_best;
    logic [DIM_W-1:0]        r_top, r_left, r_bottom, r_right;
    logic signed [SUM_W-1:0] w_prev;
    logic signed [SUM_W-1:0] w_newsum;

    // Column sums: registered read, written back in the cycle after the read
    always_ff @(posedge i_clk) begin
        r_csum_q <= r_csum_mem[i_ctl.col];
        if (r_c1.valid) begin
            r_csum_mem[r_c1.col] <= w_newsum;
        end
    end

    // Stage 1: add the element to its column sum; a fresh top row starts
    // from zero, and a single-column matrix forwards the previous sum
    always_comb begin
        if (r_c1.first_bottom) begin
            w_prev = '0;
        end else if (r_s2.valid && (r_s2.col == r_c1.col)) begin
            w_prev = r_s2_sum;
        end else begin
            w_prev = r_csum_q;
        end
        w_newsum = w_prev + {{(SUM_W-ELEM_W){i_elem[ELEM_W-1]}}, i_elem};
    end

    // Stage 2: Kadane step over the columns of this row pair
    always_comb begin
        n_cur   = r_cur;
        n_start = r_start;
        if (r_s2.valid) begin
            if (r_s2.first_col || r_cur[SUM_W-1]) begin
                n_cur   = r_s2_sum;
                n_start = r_s2.col;
            end else begin
                n_cur = r_cur + r_s2_sum;
            end
        end
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_c1 <= i_ctl;
            r_s2 <= r_c1;
            r_s3 <= r_s2;
        end
        r_s2_sum <= w_newsum;
        r_cur    <= n_cur;
        r_start  <= n_start;
    end

    // Stage 3: keep the first strictly better rectangle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_best   <= BEST_INIT;
            r_top    <= '0;
            r_left   <= '0;
            r_bottom <= '0;
            r_right  <= '0;
        end else if (r_s3.valid && (r_cur > r_best)) begin
            r_best   <= r_cur;
            r_top    <= DIM_W'(r_s3.top) + DIM_W'(1);
            r_bottom <= DIM_W'(r_s3.bottom) + DIM_W'(1);
            r_left   <= DIM_W'(r_start) + DIM_W'(1);
            r_right  <= DIM_W'(r_s3.col) + DIM_W'(1);
        end
    end

    always_comb begin
        o_result.top_row    = r_top;
        o_result.left_col   = r_left;
        o_result.bottom_row = r_bottom;
        o_result.right_col  = r_right;
        o_result.best_sum   = r_best;
    end

endmodule

[tb/tb_max_sum_submatrix.sv]
// Self-checking testbench for the max-sum submatrix block: matrix loads, search results.
module tb_max_sum_submatrix;
    timeunit 1ns;
    timeprecision 1ps;

    import mss_pkg::*;

    localparam int     ITEM_TARGET    = 1650;
    localparam int     QUIET_TAIL     = 150;
    localparam int     WATCHDOG_LIMIT = 40000;
    localparam longint SEARCH_FLOOR   = -1000000000;

    // Element value mixes for one matrix
    typedef enum int {FILL_ANY, FILL_NARROW, FILL_NEGATIVE, FILL_CORNERS} t_fill;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_in_item          i_item;
    logic              i_cfg_we;
    logic              i_cfg_addr;
    logic [DIM_W-1:0]  i_cfg_wdata;
    logic              o_valid;
    t_result           o_result;

    int                items_sent = 0;
    int                idle_cycles = 0;
    bit                gaps_on = 1'b0;

    // Dimension actually used for a raw register value
    function automatic int dim_in_use(logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Tracks configuration, element store and pending search results
    class submatrix_board;
        logic [DIM_W-1:0]         rows_raw;
        logic [DIM_W-1:0]         cols_raw;
        logic signed [ELEM_W-1:0] store [DEPTH];
        int                       load_idx;
        int                       filled;
        t_result                  pending_rects[$];
        int                       errors;

        function new();
            rows_raw = DIM_W'(1);
            cols_raw = DIM_W'(1);
            load_idx = 0;
            filled   = 0;
            errors   = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function void write_dim(logic addr, logic [DIM_W-1:0] data);
            if (addr == REG_ROW_COUNT) begin
                rows_raw = data;
            end else begin
                cols_raw = data;
            end
        endfunction

        // 2-D Kadane over every top/bottom row pair; first best wins ties
        function t_result best_rectangle();
            int      nr, nc, idx, run_left;
            longint  col_sum [MAX_DIM];
            longint  run, best;
            t_result r;
            nr   = dim_in_use(rows_raw);
            nc   = dim_in_use(cols_raw);
            best = SEARCH_FLOOR;
            r    = '0;
            for (int top = 0; top < nr; top++) begin
                foreach (col_sum[c]) col_sum[c] = 0;
                for (int bot = top; bot < nr; bot++) begin
                    for (int c = 0; c < nc; c++) begin
                        idx = bot * nc + c;
                        if (idx < DEPTH) col_sum[c] += store[idx];
                    end
                    run      = col_sum[0];
                    run_left = 0;
                    for (int c = 0; c < nc; c++) begin
                        if (c > 0) begin
                            if (run < 0) begin
                                run      = col_sum[c];
                                run_left = c;
                            end else begin
                                run += col_sum[c];
                            end
                        end
                        if (run > best) begin
                            best         = run;
                            r.top_row    = DIM_W'(top + 1);
                            r.bottom_row = DIM_W'(bot + 1);
                            r.left_col   = DIM_W'(run_left + 1);
                            r.right_col  = DIM_W'(c + 1);
                        end
                    end
                end
            end
            r.best_sum = best[SUM_W-1:0];
            return r;
        endfunction

        // Accepted item: store it if there is room, search on the last mark
        function void note_element(t_in_item it);
            int lim;
            lim = dim_in_use(rows_raw) * dim_in_use(cols_raw);
            if (lim > DEPTH) lim = DEPTH;
            if (load_idx < lim) begin
                store[load_idx] = it.element;
                load_idx++;
                if (load_idx > filled) filled = load_idx;
            end
            if (it.last_element) begin
                pending_rects.push_back(best_rectangle());
                load_idx = 0;
            end
        endfunction

        function void compare_field(string name, logic [SUM_W-1:0] want,
                                    logic [SUM_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h",
                         $time, name, want, got);
            end
        endfunction

        function void check_rect(t_result got);
            t_result want;
            if (pending_rects.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual sum 0x%h",
                         $time, got.best_sum);
                return;
            end
            want = pending_rects.pop_front();
            compare_field("top_row", SUM_W'(want.top_row), SUM_W'(got.top_row));
            compare_field("left_col", SUM_W'(want.left_col), SUM_W'(got.left_col));
            compare_field("bottom_row", SUM_W'(want.bottom_row), SUM_W'(got.bottom_row));
            compare_field("right_col", SUM_W'(want.right_col), SUM_W'(got.right_col));
            compare_field("best_sum", want.best_sum, got.best_sum);
        endfunction
    endclass

    submatrix_board board;

    max_sum_submatrix i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    always #6 i_clk = ~i_clk;

    // Observe register writes, accepted items and results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) board.write_dim(i_cfg_addr, i_cfg_wdata);
            if (start && !busy) board.note_element(i_item);
            if (o_valid) board.check_rect(o_result);
        end
    end

    // Watchdog: too long with nothing accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // All drive tasks start and end at a falling edge
    task automatic write_reg(input logic addr, input logic [DIM_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic send_element(input logic signed [ELEM_W-1:0] e, input logic last);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        start               = 1'b1;
        i_item.element      = e;
        i_item.last_element = last;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
        items_sent++;
    endtask

    // Wait for every pending result and for the search to wind down
    task automatic settle();
        while (board.pending_rects.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
        settle();
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COL_COUNT, cols);
    endtask

    function automatic logic signed [ELEM_W-1:0] draw_element(t_fill fill);
        logic signed [ELEM_W-1:0] v;
        case (fill)
            FILL_NARROW: begin
                v = ELEM_W'(int'($urandom_range(0, 16)) - 8);
            end
            FILL_NEGATIVE: begin
                if ($urandom_range(0, 7) == 0) v = ELEM_W'($urandom_range(0, 300));
                else v = ELEM_W'(-int'($urandom_range(1, 32768)));
            end
            FILL_CORNERS: begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh8000;
                    1: v = 16'sh7fff;
                    2: v = '0;
                    default: v = -16'sd1;
                endcase
            end
            default: begin
                v = ELEM_W'($urandom_range(0, 65535));
            end
        endcase
        return v;
    endfunction

    task automatic send_matrix(input int n, input t_fill fill);
        for (int i = 0; i < n; i++) begin
            send_element(draw_element(fill), i == n - 1);
        end
    endtask

    initial begin
        logic [DIM_W-1:0] rows, cols;
        int               rc, n, phase;
        bit               quiet;

        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = REG_ROW_COUNT;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        board       = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset dimensions, largest element
        send_element(16'sh7fff, 1'b1);
        // zero dimensions act as one, smallest element
        set_dims('0, '0);
        send_element(16'sh8000, 1'b1);
        // all negative 2x2
        set_dims(DIM_W'(2), DIM_W'(2));
        send_element(-16'sd1, 1'b0);
        send_element(-16'sd2, 1'b0);
        send_element(-16'sd3, 1'b0);
        send_element(-16'sd4, 1'b1);
        // equal candidates, then extra elements past the matrix size are dropped
        send_element(16'sd1, 1'b0);
        send_element(-16'sd1, 1'b0);
        send_element(16'sd1, 1'b0);
        send_element(-16'sd1, 1'b0);
        send_element(16'sd7, 1'b0);
        send_element(16'sd7, 1'b1);
        // early last mark: remaining slots keep the previous matrix
        send_element(16'sd5, 1'b0);
        send_element(16'sd6, 1'b1);
        // column count changed partway through a load
        settle();
        send_element(16'sh7fff, 1'b0);
        send_element(16'sh8000, 1'b0);
        settle();
        write_reg(REG_COL_COUNT, DIM_W'(3));
        send_element(16'sh7fff, 1'b0);
        send_element(16'sh7fff, 1'b0);
        send_element(-16'sd100, 1'b0);
        send_element(16'sh7fff, 1'b1);
        // extremes only
        set_dims(DIM_W'(2), DIM_W'(2));
        send_element(16'sh8000, 1'b0);
        send_element(16'sh8000, 1'b0);
        send_element(16'sh8000, 1'b0);
        send_element(16'sh8000, 1'b1);

        // Random phases: mostly small matrices, a few tall or wide ones
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            quiet = items_sent > ITEM_TARGET - QUIET_TAIL;
            if (phase == 2) begin
                rows = DIM_W'(MAX_DIM);
                cols = DIM_W'($urandom_range(1, 3));
            end else if (phase == 7) begin
                rows = DIM_W'($urandom_range(1, 3));
                cols = DIM_W'(127);
            end else if (phase == 12) begin
                rows = DIM_W'(127);
                cols = DIM_W'(1);
            end else if ($urandom_range(0, 39) == 0) begin
                rows = DIM_W'($urandom_range(64, 127));
                cols = DIM_W'($urandom_range(0, 3));
            end else if ($urandom_range(0, 39) == 0) begin
                rows = DIM_W'($urandom_range(0, 3));
                cols = DIM_W'($urandom_range(64, 127));
            end else begin
                rows = DIM_W'($urandom_range(0, 6));
                cols = DIM_W'($urandom_range(0, 6));
            end
            set_dims(rows, cols);
            rc = dim_in_use(rows) * dim_in_use(cols);
            repeat ($urandom_range(1, 3)) begin
                gaps_on = !quiet && ($urandom_range(0, 2) != 0);
                case ($urandom_range(0, 9))
                    0: n = rc + $urandom_range(1, 4);
                    1: n = (rc > 1 && board.filled >= rc) ? $urandom_range(1, rc - 1) : rc;
                    default: n = rc;
                endcase
                send_matrix(n, t_fill'($urandom_range(0, 3)));
            end
            phase++;
        end

        // Drain
        gaps_on = 1'b0;
        while (board.pending_rects.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending_rects.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[max_sum_submatrix.f]
hdl/mss_pkg.sv
hdl/mss_seq.sv
hdl/mss_kadane.sv
hdl/max_sum_submatrix.sv
tb/tb_max_sum_submatrix.sv
